// ----- sv/grd_pkg.sv -----
// ----------------------------------------------------------------------------
// grd_pkg
// Shared types, constants and helpers of the gray to RGBA downscale and
// mirror block.
// ----------------------------------------------------------------------------
package grd_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Width of a raw size register and of the compare that clamps it.
  localparam int SIZE_REG_W = 13;
  localparam int SIZE_CMP_W = 14;

  localparam int COORD_W = 12;
  localparam int PAIR_W  = 9;
  localparam int SUM_W   = 10;
  localparam int RGBA_W  = 32;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF_SCALE = 2'd2;
  localparam logic [1:0] REG_MIRROR_ON  = 2'd3;

  localparam logic [SIZE_REG_W-1:0] SRC_WIDTH_RST  = 13'd640;
  localparam logic [SIZE_REG_W-1:0] SRC_HEIGHT_RST = 13'd480;

  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;
  localparam logic [SUM_W:0]   BOX_ROUND    = 11'd4;

  typedef struct packed {
    logic [SIZE_REG_W-1:0] src_width;
    logic [SIZE_REG_W-1:0] src_height;
    logic                  half_scale;
    logic                  mirror_on;
  } cfg_t;

  // One pending request between the position stage and the output stage.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PAIR_W-1:0]  val;
    logic               half;
    logic               frame_end;
  } pix_t;

  function automatic logic [RGBA_W-1:0] make_rgba(input logic [7:0] g);
    make_rgba = {ALPHA_OPAQUE, g, g, g};
  endfunction

endpackage

// ----- sv/grd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// grd_cfg_regs
// APB-style register file holding the source size and mode bits.
// ----------------------------------------------------------------------------
module grd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [grd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [grd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [grd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output grd_pkg::cfg_t                  cfg
);

  grd_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= grd_pkg::SRC_WIDTH_RST;
      cfg_r.src_height <= grd_pkg::SRC_HEIGHT_RST;
      cfg_r.half_scale <= 1'b0;
      cfg_r.mirror_on  <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        grd_pkg::REG_SRC_WIDTH:  cfg_r.src_width  <= pwdata[grd_pkg::SIZE_REG_W-1:0];
        grd_pkg::REG_SRC_HEIGHT: cfg_r.src_height <= pwdata[grd_pkg::SIZE_REG_W-1:0];
        grd_pkg::REG_HALF_SCALE: cfg_r.half_scale <= pwdata[0];
        grd_pkg::REG_MIRROR_ON:  cfg_r.mirror_on  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      grd_pkg::REG_SRC_WIDTH:  prdata = grd_pkg::APB_DATA_W'(cfg_r.src_width);
      grd_pkg::REG_SRC_HEIGHT: prdata = grd_pkg::APB_DATA_W'(cfg_r.src_height);
      grd_pkg::REG_HALF_SCALE: prdata = grd_pkg::APB_DATA_W'(cfg_r.half_scale);
      grd_pkg::REG_MIRROR_ON:  prdata = grd_pkg::APB_DATA_W'(cfg_r.mirror_on);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- sv/grd_line_ram.sv -----
// ----------------------------------------------------------------------------
// grd_line_ram
// Single-port line memory of horizontal pair sums with a registered read.
// ----------------------------------------------------------------------------
module grd_line_ram #(
  parameter int DEPTH = grd_pkg::MAX_WIDTH_DEF / 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [AW-1:0]              addr,
  input  logic [grd_pkg::PAIR_W-1:0] wdata,
  output logic [grd_pkg::PAIR_W-1:0] rdata
);

  logic [grd_pkg::PAIR_W-1:0] mem [DEPTH];
  logic [grd_pkg::PAIR_W-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

// ----- sv/grd_front.sv -----
// ----------------------------------------------------------------------------
// grd_front
// Input stage: frame position counters, held left pixel, destination
// coordinates and line memory control. Holds one pending request.
// ----------------------------------------------------------------------------
module grd_front #(
  parameter int MAX_WIDTH  = grd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = grd_pkg::MAX_HEIGHT_DEF,
  parameter int LINE_DEPTH = MAX_WIDTH / 2,
  parameter int LAW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  grd_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_gray,
  input  logic                       s1_take,
  output logic                       s1_valid,
  output grd_pkg::pix_t              s1_pix,
  output logic                       ram_we,
  output logic                       ram_re,
  output logic [LAW-1:0]             ram_addr,
  output logic [grd_pkg::PAIR_W-1:0] ram_wdata
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SW = $clog2(MAX_WIDTH + 1);
  localparam int SH = $clog2(MAX_HEIGHT + 1);
  localparam int XW = grd_pkg::COORD_W;

  logic [CW-1:0] col_count_r, col_count_nxt;
  logic [RW-1:0] row_count_r, row_count_nxt;
  logic [7:0]    left_r;
  logic          s1_valid_r, s1_valid_nxt;
  grd_pkg::pix_t s1_pix_r, pix_nxt;

  logic          acc;
  logic [SW-1:0] w, dw, col_inc;
  logic [SH-1:0] h, dh, row_inc;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [SW-1:0] xs;
  logic [SH-1:0] ys;
  logic          col_wrap;
  logic          emit;
  logic [grd_pkg::PAIR_W-1:0] pair;

  assign acc      = in_valid && !in_stall;
  assign in_stall = s1_valid_r && !s1_take;
  assign s1_valid = s1_valid_r;
  assign s1_pix   = s1_pix_r;

  // Out-of-range sizes are clamped to 1..MAX.
  always_comb begin
    if (cfg.src_width == '0) begin
      w = SW'(1);
    end else if ({1'b0, cfg.src_width} > grd_pkg::SIZE_CMP_W'(MAX_WIDTH)) begin
      w = SW'(MAX_WIDTH);
    end else begin
      w = SW'(cfg.src_width);
    end
    if (cfg.src_height == '0) begin
      h = SH'(1);
    end else if ({1'b0, cfg.src_height} > grd_pkg::SIZE_CMP_W'(MAX_HEIGHT)) begin
      h = SH'(MAX_HEIGHT);
    end else begin
      h = SH'(cfg.src_height);
    end
  end

  // A counter left beyond a size changed mid-frame restarts at zero.
  assign col = (SW'(col_count_r) >= w) ? '0 : col_count_r;
  assign row = (SH'(row_count_r) >= h) ? '0 : row_count_r;

  assign dw      = w >> 1;
  assign dh      = h >> 1;
  assign xs      = SW'(col) >> 1;
  assign ys      = SH'(row) >> 1;
  assign col_inc = SW'(col) + SW'(1);
  assign row_inc = SH'(row) + SH'(1);
  assign col_wrap = col_inc >= w;
  assign pair    = grd_pkg::PAIR_W'(left_r) + grd_pkg::PAIR_W'(in_gray);

  assign emit      = !cfg.half_scale || (col[0] && row[0]);
  assign ram_addr  = LAW'(col >> 1);
  assign ram_wdata = pair;
  assign ram_we    = acc && cfg.half_scale && col[0] && !row[0];
  assign ram_re    = acc && cfg.half_scale && col[0] && row[0];

  always_comb begin
    pix_nxt.half = cfg.half_scale;
    if (!cfg.half_scale) begin
      pix_nxt.x = cfg.mirror_on ? XW'(w - SW'(1) - SW'(col)) : XW'(col);
      pix_nxt.y = XW'(row);
      pix_nxt.val = {1'b0, in_gray};
      pix_nxt.frame_end = (SW'(col) == w - SW'(1)) && (SH'(row) == h - SH'(1));
    end else begin
      pix_nxt.x = cfg.mirror_on ? XW'(dw - SW'(1) - xs) : XW'(xs);
      pix_nxt.y = XW'(ys);
      pix_nxt.val = pair;
      pix_nxt.frame_end = (xs == dw - SW'(1)) && (ys == dh - SH'(1));
    end
  end

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (acc) begin
      if (col_wrap) begin
        col_count_nxt = '0;
        row_count_nxt = (row_inc >= h) ? '0 : RW'(row_inc);
      end else begin
        col_count_nxt = CW'(col_inc);
        row_count_nxt = row;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_take;
    if (acc) begin
      s1_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      left_r      <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      if (acc) begin
        left_r <= in_gray;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r <= pix_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with no pending request");

  a_full_mode_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg.half_scale) |=> s1_valid_r)
    else $error("full-size pixel produced no request");

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_take) |=> (s1_valid_r && $stable(s1_pix_r)))
    else $error("pending request lost or changed before it was taken");
`endif

endmodule

// ----- sv/grd_back.sv -----
// ----------------------------------------------------------------------------
// grd_back
// Output stage: finishes the 2x2 box average, packs the RGBA word and holds
// the result register toward the sink.
// ----------------------------------------------------------------------------
module grd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  grd_pkg::pix_t               s1_pix,
  input  logic [grd_pkg::PAIR_W-1:0]  ram_rdata,
  output logic                        s1_take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [grd_pkg::COORD_W-1:0] out_x,
  output logic [grd_pkg::COORD_W-1:0] out_y,
  output logic [grd_pkg::RGBA_W-1:0]  out_rgba,
  output logic                        out_frame_end
);

  logic                        out_valid_r;
  logic [grd_pkg::COORD_W-1:0] x_r, y_r;
  logic [grd_pkg::RGBA_W-1:0]  rgba_r;
  logic                        fe_r;

  logic [grd_pkg::SUM_W-1:0]   sum;
  logic [grd_pkg::SUM_W:0]     avg;
  logic [7:0]                  gray;

  assign s1_take = !out_valid_r || !out_stall;

  // Four-pixel sum from the stored upper pair and the current lower pair.
  assign sum = grd_pkg::SUM_W'(ram_rdata) + grd_pkg::SUM_W'(s1_pix.val);
  assign avg = ((grd_pkg::SUM_W + 1)'(sum) + grd_pkg::BOX_ROUND) >> 2;
  assign gray = s1_pix.half ? 8'(avg - (grd_pkg::SUM_W + 1)'(1)) : s1_pix.val[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_valid) begin
      x_r    <= s1_pix.x;
      y_r    <= s1_pix.y;
      rgba_r <= grd_pkg::make_rgba(gray);
      fe_r   <= s1_pix.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = x_r;
  assign out_y         = y_r;
  assign out_rgba      = rgba_r;
  assign out_frame_end = fe_r;

`ifndef ASSERT_OFF
  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rgba_r[31:24] == grd_pkg::ALPHA_OPAQUE))
    else $error("result word is not opaque");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !out_valid_r) |=> out_valid_r)
    else $error("pending request not moved into a free result register");

  a_gray_replicated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((rgba_r[23:16] == rgba_r[15:8]) && (rgba_r[15:8] == rgba_r[7:0])))
    else $error("color channels differ");
`endif

endmodule

// ----- sv/gray_to_rgba_downscale_mirror.sv -----
// ----------------------------------------------------------------------------
// gray_to_rgba_downscale_mirror
// Gray raster stream to RGBA words with optional 2x2 box downscale and
// horizontal mirror; every result carries its destination x and y.
//
//   port group  direction  handshake           payload
//   in_         sink       in_valid/in_stall   in_gray
//   out_        source     out_valid/out_stall out_x, out_y, out_rgba,
//                                              out_frame_end
//   cfg_        APB slave  cfg_psel/penable    src_width, src_height,
//                                              half_scale, mirror_on
//
// One pixel is accepted every cycle while in_stall is low; a result passes
// through the request register and then the result register. The registered
// read of the pair-sum line memory lines up with the request register.
// A pixel that yields no result (half mode, even row or column) adds no request.
// A waiting result in the output register does not stop input while the
// middle stage is free; in_stall rises only when both stages hold results.
// Reset clears counters and valids; the line memory needs no clearing pass.
// ----------------------------------------------------------------------------
module gray_to_rgba_downscale_mirror #(
  parameter int MAX_WIDTH  = grd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = grd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_gray,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [grd_pkg::COORD_W-1:0]    out_x,
  output logic [grd_pkg::COORD_W-1:0]    out_y,
  output logic [grd_pkg::RGBA_W-1:0]     out_rgba,
  output logic                           out_frame_end,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [grd_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [grd_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [grd_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LAW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  grd_pkg::cfg_t              cfg;
  grd_pkg::pix_t              s1_pix;
  logic                       s1_valid;
  logic                       s1_take;
  logic                       ram_we;
  logic                       ram_re;
  logic [LAW-1:0]             ram_addr;
  logic [grd_pkg::PAIR_W-1:0] ram_wdata;
  logic [grd_pkg::PAIR_W-1:0] ram_rdata;

  grd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  grd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .LINE_DEPTH (LINE_DEPTH),
    .LAW        (LAW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_gray   (in_gray),
    .s1_take   (s1_take),
    .s1_valid  (s1_valid),
    .s1_pix    (s1_pix),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata)
  );

  grd_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (LAW)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  grd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid),
    .s1_pix        (s1_pix),
    .ram_rdata     (ram_rdata),
    .s1_take       (s1_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_rgba      (out_rgba),
    .out_frame_end (out_frame_end)
  );

endmodule
